@@ src/atrlc_pkg.sv @@
// Shared types, constants and keyword table for the AT response line classifier.
`default_nettype none
package atrlc_pkg;

  localparam int unsigned LINE_LEN_MAX = 1024;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned LEN_CAP_INT  = (LINE_LEN_MAX < 2047) ? LINE_LEN_MAX : 2047;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  localparam int unsigned KW_COUNT = 4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [2:0] RESP_NONE       = 3'd0;
  localparam logic [2:0] RESP_OK         = 3'd1;
  localparam logic [2:0] RESP_ERROR      = 3'd2;
  localparam logic [2:0] RESP_CONNECT    = 3'd3;
  localparam logic [2:0] RESP_NO_CARRIER = 3'd4;

  localparam logic [1:0] KW_OK         = 2'd0;
  localparam logic [1:0] KW_ERROR      = 2'd1;
  localparam logic [1:0] KW_CONNECT    = 2'd2;
  localparam logic [1:0] KW_NO_CARRIER = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_command;
  } in_t;

  typedef struct packed {
    logic [2:0]       response_code;
    logic [LEN_W-1:0] line_length;
    logic [3:0]       seen_mask;
  } out_t;

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] len;
    unique case (k)
      KW_OK:         len = 4'd2;
      KW_ERROR:      len = 4'd5;
      KW_CONNECT:    len = 4'd7;
      KW_NO_CARRIER: len = 4'd10;
      default:       len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] pos);
    localparam logic [0:9][7:0] T_OK  = {"OK", 64'h0};
    localparam logic [0:9][7:0] T_ERR = {"ERROR", 40'h0};
    localparam logic [0:9][7:0] T_CON = {"CONNECT", 24'h0};
    localparam logic [0:9][7:0] T_NOC = "NO CARRIER";
    logic [7:0] c;
    c = 8'h00;
    if (pos < 4'd10) begin
      unique case (k)
        KW_OK:         c = T_OK[pos];
        KW_ERROR:      c = T_ERR[pos];
        KW_CONNECT:    c = T_CON[pos];
        KW_NO_CARRIER: c = T_NOC[pos];
        default:       c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/at_response_line_classifier.sv @@
// Top level: frames CR LF lines and classifies each by its leading AT response keyword.
// A beat is held in the input register; a line-ending beat then loads the result register.
// Throughput: one beat per cycle; limited only by the result register being taken.
// The input register and result register part the two sides; input stays ready while
// a finished result waits, as long as the staged beat can move on.
// Reset (rst_n low, synchronous): no beats held, mask clear, line state empty.
`default_nettype none
module at_response_line_classifier (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire atrlc_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output atrlc_pkg::out_t       out_data
);
  import atrlc_pkg::*;

  logic             s1_valid_r;
  in_t              s1_r;
  logic             out_valid_r;
  out_t             out_r;

  logic             cr_seen_r;
  logic [LEN_W-1:0] line_count_r;
  logic [3:0]       alive_r;
  logic [3:0]       mask_r;

  logic             s1_adv;
  logic             line_end;
  logic [7:0]       folded;
  logic [3:0]       alive_nxt;
  logic [LEN_W-1:0] count_nxt;
  logic [2:0]       code_nxt;
  logic [3:0]       mask_nxt;
  logic [1:0]       kw_idx [KW_COUNT];

  assign folded   = fold_upper(s1_r.rx_byte);
  assign line_end = !s1_r.start_command && (s1_r.rx_byte == CHAR_LF) && cr_seen_r;
  assign count_nxt = (line_count_r < LEN_CAP) ? line_count_r + 1'b1 : line_count_r;

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_idx[k] = 2'(k);
    end
  end

  always_comb begin
    alive_nxt = alive_r;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (line_count_r < LEN_W'(kw_len(kw_idx[k]))) begin
        if (folded != kw_char(kw_idx[k], line_count_r[3:0])) begin
          alive_nxt[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    code_nxt = RESP_NONE;
    mask_nxt = mask_r;
    priority if (alive_nxt[KW_OK]) begin
      code_nxt = RESP_OK;
      mask_nxt[KW_OK] = 1'b1;
    end else if (alive_nxt[KW_ERROR]) begin
      code_nxt = RESP_ERROR;
      mask_nxt[KW_ERROR] = 1'b1;
    end else if (alive_nxt[KW_CONNECT]) begin
      code_nxt = RESP_CONNECT;
      mask_nxt[KW_CONNECT] = 1'b1;
    end else if (alive_nxt[KW_NO_CARRIER]) begin
      code_nxt = RESP_NO_CARRIER;
      mask_nxt[KW_NO_CARRIER] = 1'b1;
    end else begin
      code_nxt = RESP_NONE;
    end
  end

  assign s1_adv   = s1_valid_r && (!line_end || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cr_seen_r    <= 1'b0;
      line_count_r <= '0;
      alive_r      <= 4'hF;
      mask_r       <= 4'h0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv && line_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_r.start_command) begin
          cr_seen_r    <= 1'b0;
          line_count_r <= '0;
          alive_r      <= 4'hF;
          mask_r       <= 4'h0;
        end else if (line_end) begin
          cr_seen_r    <= 1'b0;
          line_count_r <= '0;
          alive_r      <= 4'hF;
          mask_r       <= mask_nxt;
        end else begin
          cr_seen_r    <= (s1_r.rx_byte == CHAR_CR);
          line_count_r <= count_nxt;
          alive_r      <= alive_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv && line_end) begin
      out_r.response_code <= code_nxt;
      out_r.line_length   <= count_nxt;
      out_r.seen_mask     <= mask_nxt;
    end
  end

  a_code_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.response_code != RESP_NONE |->
      out_data.seen_mask[out_data.response_code[1:0] - 2'd1]
      || out_data.response_code == RESP_NO_CARRIER)
    else $error("reported keyword missing from seen mask");

  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_length >= LEN_W'(2))
    else $error("finished line shorter than CR LF");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty stage");

endmodule
`default_nettype wire
